// ----- hw/rtl/suf_pkg.sv -----
// ----------------------------------------------------------------------------
// suf_pkg
// Shared types and constants of the sequence unwrap / duplicate filter.
// ----------------------------------------------------------------------------
package suf_pkg;

  // Seen map geometry: MAP_ENTRIES must be a power of two.
  localparam int MAP_ENTRIES   = 65536;
  localparam int MAP_BITS      = $clog2(MAP_ENTRIES);
  localparam int ROW_WIDTH     = 16;
  localparam int ROW_SEL_BITS  = $clog2(ROW_WIDTH);
  localparam int MAP_ROWS      = MAP_ENTRIES / ROW_WIDTH;
  localparam int ROW_ADDR_BITS = MAP_BITS - ROW_SEL_BITS;

  localparam logic [15:0] HALF_WINDOW      = 16'd128;
  localparam logic [15:0] WRAP_STEP        = 16'd256;
  localparam logic [15:0] WINDOW_RESET     = 16'd30000;
  localparam logic [11:0] MIN_LENGTH       = 12'd161;
  localparam logic [11:0] REDUNDANT_LENGTH = 12'd321;

  // Result group queue
  localparam int QUEUE_DEPTH    = 4;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  typedef logic [15:0] seq_t;

  // One seen map claim issued by the unwrap stage
  typedef struct packed {
    logic valid;
    seq_t cand;     // extended sequence of the item
    seq_t seq;      // sequence whose map bit is claimed
    logic red;      // claim for the redundant copy (cand - 1)
    logic last_op;  // final claim of the item
  } claim_op_t;

  // Claim outcome of one item, pushed to the result queue
  typedef struct packed {
    logic valid;
    seq_t cand;
    logic p_hit;
    logic r_hit;
  } group_t;

endpackage

// ----- hw/rtl/suf_unwrap.sv -----
// ----------------------------------------------------------------------------
// suf_unwrap
// Input stage: holds one header, unwraps the wire sequence against the
// latest sequence, advances it and issues one or two seen map claims.
// ----------------------------------------------------------------------------
module suf_unwrap (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          seq_byte,
  input  logic [11:0]         packet_length,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_wdata,
  input  logic                busy,
  input  logic                room,
  output suf_pkg::claim_op_t  op
);
  import suf_pkg::*;

  seq_t        latest;
  seq_t        window;
  logic        a_valid;
  logic        a_phase;
  logic [7:0]  a_wire;
  logic [11:0] a_len;
  seq_t        a_cand;

  seq_t base;
  seq_t cand_c;
  seq_t diff_dn;
  seq_t diff_up;
  seq_t jump;
  logic advance;
  logic need_red;
  logic issue;
  logic a_done;
  logic accept;

  always_comb begin
    base    = {latest[15:8], a_wire};
    diff_dn = latest - base;
    diff_up = base - latest;
    cand_c  = base;
    if (base < latest && diff_dn > HALF_WINDOW) begin
      cand_c = base + WRAP_STEP;
    end else if (base > latest && diff_up > HALF_WINDOW) begin
      cand_c = base - WRAP_STEP;
    end
    jump     = cand_c - latest;
    advance  = (cand_c > latest) && (jump < window);
    need_red = (a_len == REDUNDANT_LENGTH) && (cand_c != '0);
  end

  // Phase 0 claims the primary sequence and needs queue room; phase 1 follows it.
  assign issue    = a_valid && (a_phase || room);
  assign a_done   = issue && (a_phase || !need_red);
  assign in_ready = !busy && (!a_valid || a_done);
  assign accept   = in_valid && in_ready;

  always_comb begin
    op.valid   = issue;
    op.cand    = a_phase ? a_cand : cand_c;
    op.seq     = a_phase ? (a_cand - 16'd1) : cand_c;
    op.red     = a_phase;
    op.last_op = a_phase || !need_red;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      latest  <= '0;
      window  <= WINDOW_RESET;
      a_valid <= 1'b0;
      a_phase <= 1'b0;
    end else begin
      if (cfg_we) begin
        window <= cfg_wdata;
      end
      if (issue && !a_phase && advance) begin
        latest <= cand_c;
      end
      if (accept) begin
        // drop short packets right here
        a_valid <= (packet_length >= MIN_LENGTH);
        a_phase <= 1'b0;
      end else if (a_done) begin
        a_valid <= 1'b0;
        a_phase <= 1'b0;
      end else if (issue) begin
        a_phase <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_wire <= seq_byte;
      a_len  <= packet_length;
    end
    if (issue && !a_phase) begin
      a_cand <= cand_c;
    end
  end

endmodule

// ----- hw/rtl/suf_seen_map.sv -----
// ----------------------------------------------------------------------------
// suf_seen_map
// Seen bitmap in a synchronous memory of 16-bit rows: read on issue,
// test and set in the cycle after, forwarding the last written row.
// Clears itself row by row after reset.
// ----------------------------------------------------------------------------
module suf_seen_map (
  input  logic                clk,
  input  logic                rst,
  input  suf_pkg::claim_op_t  op,
  output logic                busy,
  output suf_pkg::group_t     grp
);
  import suf_pkg::*;

  logic [ROW_WIDTH-1:0] mem [MAP_ROWS];

  logic [ROW_ADDR_BITS-1:0] clr_row;
  logic                     clearing;

  claim_op_t                b_op;
  logic                     b_valid;
  logic [ROW_WIDTH-1:0]     rdata;
  logic                     p_hit;

  logic                     lw_valid;
  logic [ROW_ADDR_BITS-1:0] lw_row;
  logic [ROW_WIDTH-1:0]     lw_data;

  logic [ROW_ADDR_BITS-1:0] op_row;
  logic [ROW_ADDR_BITS-1:0] b_row;
  logic [ROW_SEL_BITS-1:0]  b_bit;
  logic [ROW_WIDTH-1:0]     row_base;
  logic [ROW_WIDTH-1:0]     row_new;
  logic                     hit;

  logic                     mem_we;
  logic [ROW_ADDR_BITS-1:0] mem_waddr;
  logic [ROW_WIDTH-1:0]     mem_wdata;

  assign op_row = op.seq[MAP_BITS-1:ROW_SEL_BITS];
  assign b_row  = b_op.seq[MAP_BITS-1:ROW_SEL_BITS];
  assign b_bit  = b_op.seq[ROW_SEL_BITS-1:0];

  always_comb begin
    // the row written last cycle was not yet in memory when this read ran
    row_base = (lw_valid && lw_row == b_row) ? lw_data : rdata;
    hit      = !row_base[b_bit];
    row_new  = row_base | (ROW_WIDTH'(1) << b_bit);
  end

  always_comb begin
    mem_we    = clearing || b_valid;
    mem_waddr = clearing ? clr_row : b_row;
    mem_wdata = clearing ? '0 : row_new;
  end

  always_comb begin
    grp.cand  = b_op.cand;
    grp.p_hit = b_op.red ? p_hit : hit;
    grp.r_hit = b_op.red && hit;
    grp.valid = b_valid && b_op.last_op && (grp.p_hit || grp.r_hit);
  end

  assign busy = clearing;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (op.valid) begin
      rdata <= mem[op_row];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_row  <= '0;
      b_valid  <= 1'b0;
      lw_valid <= 1'b0;
    end else begin
      if (clearing) begin
        clr_row <= clr_row + 1'b1;
        if (clr_row == ROW_ADDR_BITS'(MAP_ROWS - 1)) begin
          clearing <= 1'b0;
        end
      end
      b_valid  <= op.valid;
      lw_valid <= b_valid && !clearing;
    end
  end

  always_ff @(posedge clk) begin
    if (op.valid) begin
      b_op <= op;
    end
    if (b_valid && !b_op.red) begin
      p_hit <= hit;
    end
    lw_row  <= b_row;
    lw_data <= row_new;
  end

endmodule

// ----- hw/rtl/suf_result_queue.sv -----
// ----------------------------------------------------------------------------
// suf_result_queue
// Queue of claim outcomes per item and the output register that emits the
// primary result, then the redundant one, with the last flag.
// ----------------------------------------------------------------------------
module suf_result_queue (
  input  logic             clk,
  input  logic             rst,
  input  suf_pkg::group_t  grp,
  output logic             room,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [15:0]      forward_seq,
  output logic             from_redundant,
  output logic             last
);
  import suf_pkg::*;

  group_t                    fifo [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr;
  logic [QUEUE_PTR_BITS-1:0] rd_ptr;
  logic [QUEUE_CNT_BITS-1:0] count;

  seq_t cur_cand;
  logic cur_p;
  logic cur_r;

  logic fire;
  logic cur_done;
  logic load;

  // Room for this item and one item still in the map stage
  assign room = count <= QUEUE_CNT_BITS'(QUEUE_DEPTH - 2);

  assign out_valid      = cur_p || cur_r;
  assign forward_seq    = cur_p ? cur_cand : (cur_cand - 16'd1);
  assign from_redundant = !cur_p;
  assign last           = !(cur_p && cur_r);

  assign fire     = out_valid && out_ready;
  assign cur_done = fire && last;
  assign load     = (!out_valid || cur_done) && (count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      cur_p  <= 1'b0;
      cur_r  <= 1'b0;
    end else begin
      if (grp.valid) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (load) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + QUEUE_CNT_BITS'(grp.valid) - QUEUE_CNT_BITS'(load);
      if (load) begin
        cur_p <= fifo[rd_ptr].p_hit;
        cur_r <= fifo[rd_ptr].r_hit;
      end else if (cur_done) begin
        cur_p <= 1'b0;
        cur_r <= 1'b0;
      end else if (fire) begin
        // primary taken, redundant result follows
        cur_p <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (grp.valid) begin
      fifo[wr_ptr] <= grp;
    end
    if (load) begin
      cur_cand <= fifo[rd_ptr].cand;
    end
  end

endmodule

// ----- hw/rtl/sequence_unwrap_duplicate_filter_unit.sv -----
// ----------------------------------------------------------------------------
// sequence_unwrap_duplicate_filter_unit
// Sequence unwrap with duplicate filter: top level.
// ----------------------------------------------------------------------------
// Each input item is a packet header (8-bit wire sequence, length). The unit
// extends the sequence to 16 bits around the latest sequence, advances the
// latest sequence within advance_window, and emits the sequence once, the
// first time it is seen; a 321-byte packet with a nonzero sequence also
// emits sequence - 1 if unseen.
// Headers under 161 bytes are taken and dropped. A header makes one claim,
// two with a redundant copy, on the single read and single write port of
// the seen map memory (one claim per cycle; the first waits for queue room).
// Results leave at one per cycle, unless out_ready is low, via a four-item
// queue. After reset the seen map is cleared one 16-bit row per cycle, all
// MAP_ENTRIES/16 (4096) rows, in_ready low, taking configuration writes.
// ----------------------------------------------------------------------------
module sequence_unwrap_duplicate_filter_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  seq_byte,
  input  logic [11:0] packet_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] forward_seq,
  output logic        from_redundant,
  output logic        last,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);
  import suf_pkg::*;

  claim_op_t op;
  group_t    grp;
  logic      busy;
  logic      room;

  suf_unwrap u_unwrap (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .seq_byte      (seq_byte),
    .packet_length (packet_length),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .busy          (busy),
    .room          (room),
    .op            (op)
  );

  suf_seen_map u_seen_map (
    .clk  (clk),
    .rst  (rst),
    .op   (op),
    .busy (busy),
    .grp  (grp)
  );

  suf_result_queue u_result_queue (
    .clk            (clk),
    .rst            (rst),
    .grp            (grp),
    .room           (room),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .forward_seq    (forward_seq),
    .from_redundant (from_redundant),
    .last           (last)
  );

endmodule

// ----- hw/rtl/suf_checker.sv -----
// ----------------------------------------------------------------------------
// suf_checker
// Port-level checks of the sequence unwrap / duplicate filter.
// ----------------------------------------------------------------------------
module suf_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] forward_seq,
  input logic        from_redundant,
  input logic        last
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(forward_seq)
      && $stable(from_redundant) && $stable(last))
    else $error("stalled result changed");

  // A redundant result always closes its item
  a_red_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && from_redundant |-> last)
    else $error("redundant result not marked last");

  // A primary result that is not last is followed by its redundant copy
  a_pair: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> out_valid && from_redundant
      && forward_seq == $past(forward_seq) - 16'd1)
    else $error("redundant result does not follow primary");

  // The map clearing pass holds off input right after reset
  a_clear_stall: assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("input taken during map clearing");

endmodule

bind sequence_unwrap_duplicate_filter_unit suf_checker u_suf_checker (
  .clk            (clk),
  .rst            (rst),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .forward_seq    (forward_seq),
  .from_redundant (from_redundant),
  .last           (last)
);

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sequence unwrap / duplicate filter unit.
// Drives packet headers under random idle and stall, predicts every
// forwarded sequence from a local copy of the latest sequence, window and
// seen map, and compares each result in order.
// ----------------------------------------------------------------------------
module testbench;
  import suf_pkg::*;

  localparam int HOLD_OFF_CYCLES = 300;
  localparam int LATENCY_SLACK   = 20;
  localparam int DRAIN_LIMIT     = 20000;
  localparam int REPORT_LIMIT    = 10;

  typedef struct packed {
    seq_t seq;
    logic red;
    logic last;
  } forward_t;

  class forward_tracker;
    bit          seen_map [MAP_ENTRIES];
    seq_t        latest;
    logic [15:0] window;
    forward_t    pending [$];
    int unsigned headers_taken;
    int unsigned forwards_checked;
    int unsigned mismatches;

    function new();
      latest           = '0;
      window           = WINDOW_RESET;
      headers_taken    = 0;
      forwards_checked = 0;
      mismatches       = 0;
    endfunction

    function bit claim(seq_t s);
      if (seen_map[s % MAP_ENTRIES]) return 1'b0;
      seen_map[s % MAP_ENTRIES] = 1'b1;
      return 1'b1;
    endfunction

    function void note_header(logic [7:0] ws, logic [11:0] len);
      seq_t     cand;
      seq_t     prev;
      bit       p_new;
      bit       r_new;
      forward_t fwd;
      if (len < MIN_LENGTH) return;
      headers_taken++;
      // extend the wire byte to the sequence nearest the latest one
      cand = {latest[15:8], ws};
      if (cand < latest && seq_t'(latest - cand) > HALF_WINDOW) begin
        cand = cand + WRAP_STEP;
      end else if (cand > latest && seq_t'(cand - latest) > HALF_WINDOW) begin
        cand = cand - WRAP_STEP;
      end
      if (cand > latest && seq_t'(cand - latest) < window) latest = cand;
      p_new = claim(cand);
      r_new = 1'b0;
      prev  = cand - 16'd1;
      if (len == REDUNDANT_LENGTH && cand != '0) r_new = claim(prev);
      if (p_new) begin
        fwd.seq  = cand;
        fwd.red  = 1'b0;
        fwd.last = !r_new;
        pending.push_back(fwd);
      end
      if (r_new) begin
        fwd.seq  = prev;
        fwd.red  = 1'b1;
        fwd.last = 1'b1;
        pending.push_back(fwd);
      end
    endfunction

    function void check_forward(seq_t seq, logic red, logic lst);
      forward_t want;
      forwards_checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected forward: seq %0d red %0b last %0b", seq, red, lst);
        return;
      end
      want = pending.pop_front();
      if (want.seq !== seq || want.red !== red || want.last !== lst) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display({"forward mismatch: expected seq %0d red %0b last %0b,",
                    " got seq %0d red %0b last %0b"},
                   want.seq, want.red, want.last, seq, red, lst);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  seq_byte = '0;
  logic [11:0] packet_length = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] forward_seq;
  logic        from_redundant;
  logic        last;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  int unsigned    send_idle_pct = 32;
  int unsigned    recv_idle_pct = 80;
  bit             hold_off_req  = 1'b0;
  seq_t           send_seq      = '0;
  forward_tracker tracker       = new();

  sequence_unwrap_duplicate_filter_unit u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .seq_byte       (seq_byte),
    .packet_length  (packet_length),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .forward_seq    (forward_seq),
    .from_redundant (from_redundant),
    .last           (last),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Sample handshakes with pre-edge values, in a fixed order.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) tracker.window = cfg_wdata;
      if (in_valid && in_ready) tracker.note_header(seq_byte, packet_length);
      if (out_valid && out_ready) tracker.check_forward(forward_seq, from_redundant, last);
    end
  end

  initial begin : receiver
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_header(input logic [7:0] ws, input logic [11:0] len);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    seq_byte      <= ws;
    packet_length <= len;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_window(input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Hold the sender until every predicted forward is out, then let the
  // pipeline settle so a header with no forward is finished too.
  task automatic drain_results();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (tracker.pending.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (LATENCY_SLACK) @(posedge clk);
  endtask

  task automatic send_random_headers(input int unsigned count);
    int unsigned taken;
    int unsigned pick;
    logic [7:0]  ws;
    logic [11:0] len;
    taken = 0;
    while (taken < count) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        // in-order stream, now and then a jump close to the half window
        send_seq = send_seq + seq_t'($urandom_range(1, 3));
        if ($urandom_range(19) == 0) send_seq = send_seq + seq_t'($urandom_range(100, 127));
        ws = send_seq[7:0];
        case ($urandom_range(9))
          0, 1, 2, 3, 4: len = REDUNDANT_LENGTH;
          5, 6, 7:       len = MIN_LENGTH;
          default:       len = 12'($urandom_range(MIN_LENGTH, 2048));
        endcase
      end else if (pick < 80) begin
        // late or repeated packet
        ws  = 8'(send_seq - seq_t'($urandom_range(0, 10)));
        len = $urandom_range(1) ? REDUNDANT_LENGTH : MIN_LENGTH;
      end else if (pick < 90) begin
        ws  = 8'($urandom_range(255));
        len = 12'($urandom_range(0, 160));
      end else begin
        ws  = 8'($urandom_range(255));
        len = 12'($urandom_range(0, 2048));
      end
      send_header(ws, len);
      if (len >= MIN_LENGTH) taken++;
    end
  endtask

  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_window(WINDOW_RESET);

    // short headers, sequence zero with and without a redundant copy
    send_header(8'd0, 12'd0);
    send_header(8'd5, 12'd160);
    send_header(8'd0, 12'd161);
    send_header(8'd0, 12'd321);
    send_header(8'd1, 12'd321);
    send_header(8'd1, 12'd161);
    // wrap below zero, half window edges, lengths next to the redundant one
    send_header(8'd255, 12'd321);
    send_header(8'd130, 12'd2048);
    send_header(8'd129, 12'd322);
    send_header(8'd200, 12'd320);
    send_header(8'h10, 12'd321);
    send_header(8'h03, 12'd321);
    send_header(8'h90, 12'd321);
    send_header(8'h11, 12'd161);
    send_header(8'h10, 12'd161);
    send_header(8'h0F, 12'd321);
    send_header(8'h8F, 12'd1000);
    drain_results();

    // window zero and one never advance
    write_window(16'd0);
    send_header(8'h20, 12'd161);
    send_header(8'h21, 12'd321);
    send_header(8'h30, 12'd161);
    drain_results();
    write_window(16'd1);
    send_header(8'h40, 12'd321);
    send_header(8'h41, 12'd161);
    drain_results();

    write_window(16'hFFFF);
    send_seq = 16'h0241;
    send_random_headers(120);
    // long receiver stall while headers keep coming
    hold_off_req = 1'b1;
    send_random_headers(130);
    drain_results();

    send_idle_pct = 80;
    recv_idle_pct = 32;
    write_window(16'($urandom_range(1, 200)));
    send_random_headers(200);
    drain_results();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_window(WINDOW_RESET);
    send_random_headers(200);
    drain_results();
    write_window(16'd2);
    send_random_headers(100);
    drain_results();

    $display("covered %0d headers of 161+ bytes and %0d forwards, %0d left unmatched",
             tracker.headers_taken, tracker.forwards_checked, tracker.pending.size());
    $display("windows 0, 1, 2, random, 30000 and 65535 under mixed idle and a long stall");
    if (tracker.mismatches == 0 && tracker.pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
